### src/charge_rate_window_tracker_macros.svh
// Assertion macros used by the charge rate window tracker checker.
`ifndef CHARGE_RATE_WINDOW_TRACKER_MACROS_SVH
`define CHARGE_RATE_WINDOW_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRWT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/crwt_pkg.sv
// Types and constants shared by the charge rate window tracker modules.
package crwt_pkg;

    localparam int VOLT_W   = 12;
    localparam int TICK_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int RATE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SQ_W     = 2 * VOLT_W;
    localparam int PADDR_W  = 5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_START  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REVERSED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOW_RISE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd4;

    // Register indexes (word address bits of paddr).
    localparam logic [2:0] REG_RATE_GAIN  = 3'd0;
    localparam logic [2:0] REG_NEAR_FULL  = 3'd1;
    localparam logic [2:0] REG_HIGH_RATE  = 3'd2;
    localparam logic [2:0] REG_MIN_RISE   = 3'd3;
    localparam logic [2:0] REG_MIN_TIME   = 3'd4;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } div_res_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] low1;
        logic [RATE_W-1:0] low2;
    } scan_res_t;

endpackage

### src/crwt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module crwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/crwt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module crwt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [crwt_pkg::RATE_W-1:0] dividend,
    input  logic [crwt_pkg::TICK_W-1:0] divisor,
    output crwt_pkg::div_res_t         res
);
    import crwt_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [TICK_W:0]   rem_reg, rem_next;
    logic [TICK_W-1:0] dvs_reg, dvs_next;
    logic [TICK_W:0]   rem_shift;
    logic [TICK_W:0]   diff;

    // Shift the next dividend bit in and try a subtraction; a zero divisor
    // always succeeds, which yields an all-ones quotient.
    assign rem_shift = {rem_reg[TICK_W-1:0], quo_reg[RATE_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[RATE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RATE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

### src/crwt_scan.sv
// Window scan: reads one entry per cycle and keeps the two smallest rates.
module crwt_scan #(
    parameter int DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [$clog2(DEPTH)-1:0]    fill,
    input  logic                        full,
    output logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic [crwt_pkg::RATE_W-1:0] rd_data,
    output crwt_pkg::scan_res_t         res
);
    import crwt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              issue_reg, issue_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              dvld_reg, dvld_next;
    logic [AW-1:0]     didx_reg, didx_next;
    logic              done_reg, done_next;
    logic [RATE_W-1:0] low1_reg, low1_next;
    logic [RATE_W-1:0] low2_reg, low2_next;
    logic [RATE_W-1:0] entry;

    // Entries past the fill point have never been written and are read as zero.
    assign entry = (full || (didx_reg < fill)) ? rd_data : '0;

    always_comb
    begin
        issue_next = issue_reg;
        addr_next  = addr_reg;
        dvld_next  = 1'b0;
        didx_next  = addr_reg;
        done_next  = 1'b0;
        low1_next  = low1_reg;
        low2_next  = low2_reg;
        if (start)
        begin
            issue_next = 1'b1;
            addr_next  = '0;
            low1_next  = '1;
            low2_next  = '1;
        end
        else
        begin
            if (issue_reg)
            begin
                dvld_next = 1'b1;
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            if (dvld_reg)
            begin
                if (entry < low2_reg)
                begin
                    if (entry < low1_reg)
                    begin
                        low2_next = low1_reg;
                        low1_next = entry;
                    end
                    else
                    begin
                        low2_next = entry;
                    end
                end
                if (didx_reg == AW'(DEPTH - 1))
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            addr_reg  <= '0;
            dvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            issue_reg <= issue_next;
            addr_reg  <= addr_next;
            dvld_reg  <= dvld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= didx_next;
        low1_reg <= low1_next;
        low2_reg <= low2_next;
    end

    assign rd_addr  = addr_reg;
    assign res.done = done_reg;
    assign res.low1 = low1_reg;
    assign res.low2 = low2_reg;

endmodule

### src/charge_rate_window_tracker.sv
// Top level of the charge rate window tracker.
//
// The block takes one charging interval per input transfer and returns one
// result transfer for it. An interval that is rejected (no start level, time
// running backwards, too small a rise, too short an interval) is answered
// without multiply, divide or scan, with both rates zero and the window untouched.
// A nearly full capacitor records the high power rate and goes only through
// the window write and scan. A computed rate passes through the squares, the
// gain product, a bit-serial restoring divider that resolves one of the 32
// quotient bits per cycle, one write into the window RAM, and a scan that
// reads one window entry per cycle from the window RAM.
// Items are processed one at a time; a finished result sits in the output
// register, so the next interval can be accepted while it waits for out_ready.
// The window starts out as all zeros: a fill count marks the entries that
// were never written, so no clearing pass is needed after reset. Registers
// are written through the APB port at byte addresses 0x00 to 0x10 and should
// only be changed while no interval is in flight.
module charge_rate_window_tracker #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [crwt_pkg::VOLT_W-1:0]   volt_begin,
    input  logic [crwt_pkg::VOLT_W-1:0]   volt_finish,
    input  logic [crwt_pkg::TICK_W-1:0]   tick_begin,
    input  logic [crwt_pkg::TICK_W-1:0]   tick_finish,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [crwt_pkg::STATUS_W-1:0] status_code,
    output logic [crwt_pkg::RATE_W-1:0]   new_rate,
    output logic [crwt_pkg::RATE_W-1:0]   pessimistic_rate,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crwt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import crwt_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_SCALE  = 3'd2;
    localparam logic [2:0] S_DIVGO  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // Configuration registers.
    logic [GAIN_W-1:0] gain_reg;
    logic [VOLT_W-1:0] near_full_reg;
    logic [RATE_W-1:0] high_rate_reg;
    logic [VOLT_W-1:0] min_rise_reg;
    logic [TICK_W-1:0] min_time_reg;
    logic              cfg_we;
    logic [2:0]        cfg_idx;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    logic [VOLT_W-1:0]   vb_reg, vf_reg;
    logic [TICK_W-1:0]   elapsed_reg;
    logic [SQ_W-1:0]     sqf_reg, sqb_reg;
    logic [RATE_W-1:0]   prod_reg;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RATE_W-1:0]   res_new_reg, res_new_next;
    logic [RATE_W-1:0]   res_pess_reg, res_pess_next;
    logic [STATUS_W-1:0] status_code_reg;
    logic [RATE_W-1:0]   new_rate_reg;
    logic [RATE_W-1:0]   pess_rate_reg;

    // Interval checks on the incoming transfer.
    logic [TICK_W-1:0] elapsed;
    logic              chk_no_start, chk_reversed, chk_near_full, chk_low_rise, chk_short;
    logic              accept;
    logic              load_out;
    logic [RATE_W-1:0] energy;

    // Submodule connections.
    div_res_t          div_res;
    scan_res_t         scan_res;
    logic              div_start;
    logic              scan_start;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [RATE_W-1:0] ram_rdata;

    // ---------------------------------------------------------------------
    // APB register file. Writes land in the access phase; pready is tied
    // high, so every transfer completes without wait states.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_W'(100);
            near_full_reg <= VOLT_W'(3800);
            high_rate_reg <= RATE_W'(1000);
            min_rise_reg  <= VOLT_W'(2);
            min_time_reg  <= TICK_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_RATE_GAIN: gain_reg      <= pwdata[GAIN_W-1:0];
                REG_NEAR_FULL: near_full_reg <= pwdata[VOLT_W-1:0];
                REG_HIGH_RATE: high_rate_reg <= pwdata;
                REG_MIN_RISE:  min_rise_reg  <= pwdata[VOLT_W-1:0];
                REG_MIN_TIME:  min_time_reg  <= pwdata[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RATE_GAIN: prdata = 32'(gain_reg);
            REG_NEAR_FULL: prdata = 32'(near_full_reg);
            REG_HIGH_RATE: prdata = high_rate_reg;
            REG_MIN_RISE:  prdata = 32'(min_rise_reg);
            REG_MIN_TIME:  prdata = 32'(min_time_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Interval checks. They are evaluated on the input transfer itself, in
    // the order: no start, time reversed, nearly full (accepted at once),
    // rise too small, interval too short.
    // ---------------------------------------------------------------------
    assign elapsed       = tick_finish - tick_begin;
    assign chk_no_start  = (volt_begin == '0);
    assign chk_reversed  = (tick_finish < tick_begin);
    assign chk_near_full = (volt_finish >= near_full_reg);
    assign chk_low_rise  = (({1'b0, volt_begin} + {1'b0, min_rise_reg}) >= {1'b0, volt_finish});
    assign chk_short     = (elapsed < min_time_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // The output register can take a new result when it is empty or when
    // its current result leaves in this cycle.
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Charged energy wraps modulo 2^32 like the product that follows it.
    assign energy = RATE_W'(sqf_reg) - RATE_W'(sqb_reg);

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        full_next       = full_reg;
        rate_next       = rate_reg;
        res_status_next = res_status_reg;
        res_new_next    = res_new_reg;
        res_pess_next   = res_pess_reg;
        div_start       = 1'b0;
        scan_start      = 1'b0;
        ram_we          = 1'b0;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_new_next  = '0;
                    res_pess_next = '0;
                    if (chk_no_start)
                    begin
                        res_status_next = ST_NO_START;
                        state_next      = S_DONE;
                    end
                    else if (chk_reversed)
                    begin
                        res_status_next = ST_REVERSED;
                        state_next      = S_DONE;
                    end
                    else if (chk_near_full)
                    begin
                        rate_next  = high_rate_reg;
                        state_next = S_WRITE;
                    end
                    else if (chk_low_rise)
                    begin
                        res_status_next = ST_LOW_RISE;
                        state_next      = S_DONE;
                    end
                    else if (chk_short)
                    begin
                        res_status_next = ST_TOO_SHORT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SQUARE;
                    end
                end
            end
            S_SQUARE: state_next = S_SCALE;
            S_SCALE:  state_next = S_DIVGO;
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    rate_next  = div_res.quotient;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // Store the rate and advance the ring; the scan sees the
                // updated fill count and wrap flag from its first compare on.
                ram_we     = 1'b1;
                scan_start = 1'b1;
                if (slot_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    slot_next = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    res_status_next = ST_OK;
                    res_new_next    = rate_reg;
                    res_pess_next   = full_reg ? scan_res.low2 : scan_res.low1;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers: two squares, then the gain product, each behind
    // its own register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vb_reg      <= volt_begin;
            vf_reg      <= volt_finish;
            elapsed_reg <= elapsed;
        end
        if (state_reg == S_SQUARE)
        begin
            sqf_reg <= vf_reg * vf_reg;
            sqb_reg <= vb_reg * vb_reg;
        end
        if (state_reg == S_SCALE)
        begin
            prod_reg <= RATE_W'(gain_reg * energy);
        end
        rate_reg       <= rate_next;
        res_status_reg <= res_status_next;
        res_new_reg    <= res_new_next;
        res_pess_reg   <= res_pess_next;
        if (load_out)
        begin
            status_code_reg <= res_status_reg;
            new_rate_reg    <= res_new_reg;
            pess_rate_reg   <= res_pess_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status_code      = status_code_reg;
    assign new_rate         = new_rate_reg;
    assign pessimistic_rate = pess_rate_reg;

    // ---------------------------------------------------------------------
    // Divider, window memory and scan unit.
    // ---------------------------------------------------------------------
    crwt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (elapsed_reg),
        .res      (div_res)
    );

    crwt_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (rate_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crwt_scan #(
        .DEPTH (WINDOW_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .fill    (slot_reg),
        .full    (full_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .res     (scan_res)
    );

endmodule

### src/crwt_checker.sv
// Port-level checker for the charge rate window tracker, bound to the top level.
`include "charge_rate_window_tracker_macros.svh"

module crwt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [crwt_pkg::STATUS_W-1:0] status_code,
    input logic [crwt_pkg::RATE_W-1:0]   new_rate,
    input logic [crwt_pkg::RATE_W-1:0]   pessimistic_rate
);
    import crwt_pkg::*;

    // A result that is not taken stays offered.
    `CRWT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // Only one interval is in flight: ready drops right after a transfer.
    `CRWT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // A rejected interval reports zero rates.
    `CRWT_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && (status_code != ST_OK), (new_rate == '0) && (pessimistic_rate == '0))

    // Status codes stay within the defined reasons.
    `CRWT_ASSERT_NOW(a_status_range, clk, rst_n, out_valid, status_code <= ST_TOO_SHORT)

endmodule

bind charge_rate_window_tracker crwt_checker u_crwt_checker (.*);
